@@ sv/uart8_pkg.sv @@
// Shared types and constants for the 8N1 UART with receive FIFO.
package uart8_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_SEND  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_START = 2'd1,
    MODE_RX    = 2'd2,
    MODE_TX    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_FRAMING  = 2'd2
  } rx_status_t;

  localparam logic [3:0]  BIT_LAST        = 4'd9;
  localparam logic [15:0] BIT_PERIOD_INIT = 16'd1666;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } q_op_t;

  typedef struct packed {
    logic full;
    logic rd_ok;
    logic avail_nxt;
  } q_stat_t;

  typedef struct packed {
    logic       tx_line;
    logic       read_valid;
    logic       send_accepted;
    rx_status_t rx_status;
    logic       byte_available;
    logic       busy_res;
  } result_t;

endpackage

@@ sv/uart8_rxq.sv @@
// Receive ring FIFO: byte memory with registered read and its pointers.
module uart8_rxq #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  uart8_pkg::q_op_t op,
  input  logic [7:0]      wr_data,
  output uart8_pkg::q_stat_t stat,
  output logic [7:0]      rd_data
);
  import uart8_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_inc, rp_inc;
  logic [7:0]    rd_data_r;
  logic          empty;

  always_comb begin
    wp_inc = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    rp_inc = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    empty  = (wp_r == rp_r);
    stat.full  = (wp_inc == rp_r);
    stat.rd_ok = op.pop && !empty;
    priority if (op.push) begin
      wp_nxt = wp_inc;
    end else if (op.clear) begin
      wp_nxt = rp_r;
    end else begin
      wp_nxt = wp_r;
    end
    rp_nxt = stat.rd_ok ? rp_inc : rp_r;
    stat.avail_nxt = (wp_nxt != rp_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[wp_r] <= wr_data;
    end
    if (stat.rd_ok) begin
      rd_data_r <= mem[rp_r];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/uart_8n1_transceiver_with_rx_fifo.sv @@
// Top level: half-duplex 8N1 UART engine with receive FIFO and registered result.
// The result is valid on the out_ side in the cycle after the input transfer.
// Throughput: one item per cycle; in_tready = !out_tvalid | out_tready.
// FIFO reads go through the memory's registered read port, aligned with the result.
// Reset (rst_n low, synchronous): idle, pointers zero, bit_period 1666, status ok,
// tx line high; FIFO contents are not cleared and are never read before written.
module uart_8n1_transceiver_with_rx_fifo #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_level[0], tx_data[8:1], zero[15:9]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // tx_line[0], read_data[8:1], read_valid[9],
                                  // send_accepted[10], rx_status[12:11],
                                  // byte_available[13], busy_res[14], zero[15]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import uart8_pkg::*;

  logic        in_fire;
  kind_t       kind;
  logic        lvl;
  logic [7:0]  tx_data;

  logic [15:0] bit_period_r;
  mode_t       mode_r, mode_nxt;
  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic [15:0] tick_r, tick_nxt, tick_inc;
  logic [15:0] cmp_r, cmp_nxt;
  logic [7:0]  tx_shift_r, tx_shift_nxt;
  logic [7:0]  rx_shift_r, rx_shift_nxt;
  rx_status_t  status_r, status_nxt;
  logic        line_r, line_nxt;
  logic        prev_r, prev_nxt;
  logic [2:0]  idx_m1;

  q_op_t       q_op;
  q_stat_t     q_st;
  logic [7:0]  q_rdata;

  result_t     res, res_r;
  logic        out_valid_r;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign kind      = kind_t'(in_tuser);
  assign lvl       = in_tdata[0];
  assign tx_data   = in_tdata[8:1];
  assign cfg_ready = 1'b1;
  assign idx_m1    = 3'(bit_idx_r - 4'd1);
  assign tick_inc  = tick_r + 16'd1;

  // next state
  always_comb begin
    mode_nxt     = mode_r;
    bit_idx_nxt  = bit_idx_r;
    tick_nxt     = tick_r;
    cmp_nxt      = cmp_r;
    tx_shift_nxt = tx_shift_r;
    rx_shift_nxt = rx_shift_r;
    status_nxt   = status_r;
    line_nxt     = line_r;
    prev_nxt     = prev_r;
    q_op         = '0;
    if (in_fire) begin
      unique case (kind)
        KIND_TICK: begin
          prev_nxt = lvl;
          if (mode_r == MODE_IDLE) begin
            if (prev_r && !lvl) begin
              cmp_nxt  = bit_period_r >> 1;
              tick_nxt = '0;
              mode_nxt = MODE_START;
            end
          end else if (tick_inc >= cmp_r) begin
            tick_nxt = '0;
            unique case (mode_r)
              MODE_START: begin
                priority if (lvl) begin
                  mode_nxt = MODE_IDLE;
                end else if (q_st.full) begin
                  status_nxt = ST_OVERFLOW;
                  mode_nxt   = MODE_IDLE;
                end else begin
                  cmp_nxt      = bit_period_r;
                  bit_idx_nxt  = 4'd1;
                  rx_shift_nxt = '0;
                  status_nxt   = ST_OK;
                  mode_nxt     = MODE_RX;
                end
              end
              MODE_RX: begin
                if (bit_idx_r >= BIT_LAST) begin
                  if (!lvl) begin
                    status_nxt = ST_FRAMING;
                  end else begin
                    q_op.push = 1'b1;
                  end
                  bit_idx_nxt = '0;
                  mode_nxt    = MODE_IDLE;
                end else begin
                  rx_shift_nxt[idx_m1] = lvl;
                  bit_idx_nxt          = bit_idx_r + 4'd1;
                end
              end
              MODE_TX: begin
                priority if (bit_idx_r == 4'd0) begin
                  line_nxt    = 1'b0;
                  bit_idx_nxt = 4'd1;
                end else if (bit_idx_r >= BIT_LAST) begin
                  line_nxt    = 1'b1;
                  bit_idx_nxt = '0;
                  mode_nxt    = MODE_IDLE;
                end else begin
                  line_nxt    = tx_shift_r[idx_m1];
                  bit_idx_nxt = bit_idx_r + 4'd1;
                end
              end
              default: begin
              end
            endcase
          end else begin
            tick_nxt = tick_inc;
          end
        end
        KIND_SEND: begin
          if (mode_r == MODE_IDLE) begin
            tx_shift_nxt = tx_data;
            cmp_nxt      = bit_period_r;
            tick_nxt     = '0;
            bit_idx_nxt  = '0;
            mode_nxt     = MODE_TX;
          end
        end
        KIND_READ:  q_op.pop   = 1'b1;
        KIND_CLEAR: q_op.clear = 1'b1;
        default: begin
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    res.tx_line        = line_nxt;
    res.read_valid     = q_st.rd_ok;
    res.send_accepted  = (kind == KIND_SEND) && (mode_r == MODE_IDLE);
    res.rx_status      = status_nxt;
    res.byte_available = q_st.avail_nxt;
    res.busy_res       = (mode_nxt != MODE_IDLE);
  end

  uart8_rxq #(
    .DEPTH(DEPTH)
  ) u_rxq (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (q_op),
    .wr_data(rx_shift_r),
    .stat   (q_st),
    .rd_data(q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BIT_PERIOD_INIT;
      mode_r       <= MODE_IDLE;
      bit_idx_r    <= '0;
      tick_r       <= '0;
      cmp_r        <= '0;
      tx_shift_r   <= '0;
      rx_shift_r   <= '0;
      status_r     <= ST_OK;
      line_r       <= 1'b1;
      prev_r       <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bit_period_r <= cfg_data;
      end
      mode_r     <= mode_nxt;
      bit_idx_r  <= bit_idx_nxt;
      tick_r     <= tick_nxt;
      cmp_r      <= cmp_nxt;
      tx_shift_r <= tx_shift_nxt;
      rx_shift_r <= rx_shift_nxt;
      status_r   <= status_nxt;
      line_r     <= line_nxt;
      prev_r     <= prev_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.busy_res, res_r.byte_available, res_r.rx_status,
                       res_r.send_accepted, res_r.read_valid,
                       q_rdata & {8{res_r.read_valid}}, res_r.tx_line};

endmodule

@@ sv/uart8_chk.sv @@
// Port-level checker for the UART top level, bound to it.
module uart8_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("transfer without result");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[9] |-> out_tdata[8:1] == 8'd0)
    else $error("read data nonzero without read_valid");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[12:11] != 2'b11)
    else $error("bad rx status code");

  a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[14] && out_tdata[0] && !out_tdata[9])
    else $error("accepted send not busy");

endmodule

bind uart_8n1_transceiver_with_rx_fifo uart8_chk u_uart8_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

@@ tb/uart_reply_checker.sv @@
// Checker for the 8N1 UART: watches the three channels, predicts each reply and compares.
module uart_reply_checker #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_level[0], tx_data[8:1], zero[15:9]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // tx_line[0], read_data[8:1], read_valid[9],
                                  // send_accepted[10], rx_status[12:11],
                                  // byte_available[13], busy_res[14], zero[15]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          replies_pending,
  output int          replies_seen,
  output int          bytes_stored,
  output int          overflow_hits,
  output int          framing_hits,
  output int          false_starts
);
  import uart8_pkg::*;

  typedef struct packed {
    logic       busy_res;
    logic       byte_available;
    rx_status_t rx_status;
    logic       send_accepted;
    logic       read_valid;
    logic [7:0] read_data;
    logic       tx_line;
  } reply_t;

  reply_t replies_due[$];

  logic [15:0] period_reg;
  logic [7:0]  fifo_mem [DEPTH];
  int unsigned wr_idx, rd_idx;
  mode_t       line_mode;
  logic [3:0]  bit_no;
  logic [15:0] tick_cnt, cmp_val;
  logic [7:0]  tx_byte, rx_byte;
  rx_status_t  status;
  logic        tx_level, last_rx;
  int          errs, seen, n_stored, n_ovf, n_frm, n_glitch;

  task automatic on_bit_time(input logic lvl);
    case (line_mode)
      MODE_START: begin
        if (lvl) begin
          line_mode = MODE_IDLE;
          n_glitch++;
        end else if ((wr_idx + 1) % DEPTH == rd_idx) begin
          status    = ST_OVERFLOW;
          line_mode = MODE_IDLE;
          n_ovf++;
        end else begin
          cmp_val   = period_reg;
          tick_cnt  = '0;
          bit_no    = 4'd1;
          rx_byte   = '0;
          status    = ST_OK;
          line_mode = MODE_RX;
        end
      end
      MODE_RX: begin
        if (bit_no >= BIT_LAST) begin
          if (!lvl) begin
            status = ST_FRAMING;
            n_frm++;
          end else begin
            fifo_mem[wr_idx] = rx_byte;
            wr_idx = (wr_idx + 1) % DEPTH;
            n_stored++;
          end
          bit_no    = '0;
          line_mode = MODE_IDLE;
        end else begin
          rx_byte[bit_no - 4'd1] = rx_byte[bit_no - 4'd1] | lvl;
          bit_no++;
        end
      end
      MODE_TX: begin
        if (bit_no == 4'd0) begin
          tx_level = 1'b0;
          bit_no   = 4'd1;
        end else if (bit_no >= BIT_LAST) begin
          tx_level  = 1'b1;
          bit_no    = '0;
          line_mode = MODE_IDLE;
        end else begin
          tx_level = tx_byte[bit_no - 4'd1];
          bit_no++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_reply(input kind_t k, input logic lvl, input logic [7:0] d,
                               output reply_t r);
    r = '0;
    case (k)
      KIND_TICK: begin
        if (line_mode == MODE_IDLE) begin
          if (last_rx && !lvl) begin
            cmp_val   = period_reg >> 1;
            tick_cnt  = '0;
            line_mode = MODE_START;
          end
        end else begin
          tick_cnt = tick_cnt + 16'd1;
          if (tick_cnt >= cmp_val) begin
            tick_cnt = '0;
            on_bit_time(lvl);
          end
        end
        last_rx = lvl;
      end
      KIND_SEND: begin
        if (line_mode == MODE_IDLE) begin
          tx_byte         = d;
          cmp_val         = period_reg;
          tick_cnt        = '0;
          bit_no          = '0;
          line_mode       = MODE_TX;
          r.send_accepted = 1'b1;
        end
      end
      KIND_READ: begin
        if (wr_idx != rd_idx) begin
          r.read_data  = fifo_mem[rd_idx];
          r.read_valid = 1'b1;
          rd_idx = (rd_idx + 1) % DEPTH;
        end
      end
      default: wr_idx = rd_idx;
    endcase
    r.tx_line        = tx_level;
    r.rx_status      = status;
    r.byte_available = (wr_idx != rd_idx);
    r.busy_res       = (line_mode != MODE_IDLE);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errs++;
      if (errs <= 100)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    reply_t exp_r, got_r, new_r;
    if (!rst_n) begin
      replies_due.delete();
      period_reg = BIT_PERIOD_INIT;
      wr_idx     = 0;
      rd_idx     = 0;
      line_mode  = MODE_IDLE;
      bit_no     = '0;
      tick_cnt   = '0;
      cmp_val    = '0;
      tx_byte    = '0;
      rx_byte    = '0;
      status     = ST_OK;
      tx_level   = 1'b1;
      last_rx    = 1'b1;
    end else begin
      if (out_tvalid && out_tready) begin
        seen++;
        got_r = reply_t'(out_tdata[14:0]);
        if (replies_due.size() == 0) begin
          errs++;
          if (errs <= 100)
            $display("%0t: result transfer with nothing expected, actual %h", $time,
                     out_tdata);
        end else begin
          exp_r = replies_due.pop_front();
          check_field("tx_line", exp_r.tx_line, got_r.tx_line);
          check_field("read_data", exp_r.read_data, got_r.read_data);
          check_field("read_valid", exp_r.read_valid, got_r.read_valid);
          check_field("send_accepted", exp_r.send_accepted, got_r.send_accepted);
          check_field("rx_status", exp_r.rx_status, got_r.rx_status);
          check_field("byte_available", exp_r.byte_available, got_r.byte_available);
          check_field("busy_res", exp_r.busy_res, got_r.busy_res);
        end
      end
      if (cfg_valid && cfg_ready)
        period_reg = cfg_data;
      if (in_tvalid && in_tready) begin
        predict_reply(kind_t'(in_tuser), in_tdata[0], in_tdata[8:1], new_r);
        replies_due.push_back(new_r);
      end
    end
    fail_count      <= errs;
    replies_pending <= replies_due.size();
    replies_seen    <= seen;
    bytes_stored    <= n_stored;
    overflow_hits   <= n_ovf;
    framing_hits    <= n_frm;
    false_starts    <= n_glitch;
  end

  initial begin
    errs     = 0;
    seen     = 0;
    n_stored = 0;
    n_ovf    = 0;
    n_frm    = 0;
    n_glitch = 0;
  end

endmodule

@@ tb/uart_8n1_transceiver_with_rx_fifo_tb.sv @@
// Testbench top for the 8N1 UART: clock, reset, stimulus, flow control and verdict.
module uart_8n1_transceiver_with_rx_fifo_tb;
  import uart8_pkg::*;

  localparam int DEPTH      = 16;
  localparam int RAND_ITEMS = 850;

  typedef enum int {FR_GOOD, FR_BAD_STOP, FR_GLITCH} frame_form_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // rx_level[0], tx_data[8:1], zero[15:9]
  logic [1:0]  in_tuser = KIND_TICK;  // kind[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // tx_line[0], read_data[8:1], read_valid[9],
                                // send_accepted[10], rx_status[12:11],
                                // byte_available[13], busy_res[14], zero[15]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int fail_count, replies_pending, replies_seen;
  int bytes_stored, overflow_hits, framing_hits, false_starts;

  bit          calm = 1'b0;
  int          items_sent = 0;
  logic [15:0] cur_period = BIT_PERIOD_INIT;

  uart_8n1_transceiver_with_rx_fifo #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  uart_reply_checker #(.DEPTH(DEPTH)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .replies_pending(replies_pending),
    .replies_seen(replies_seen), .bytes_stored(bytes_stored),
    .overflow_hits(overflow_hits), .framing_hits(framing_hits),
    .false_starts(false_starts)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic put_item(input kind_t k, input logic lvl, input logic [7:0] d);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {7'd0, d, lvl};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic tick(input logic lvl);
    put_item(KIND_TICK, lvl, 8'($urandom));
  endtask

  task automatic host_noise();
    put_item(kind_t'($urandom_range(1, 3)), 1'($urandom), 8'($urandom));
  endtask

  // wait until every reply is back, then write the bit period
  task automatic set_period(input logic [15:0] p);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_data  <= p;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cur_period = p;
  endtask

  // one serial frame, level per tick laid out so each sample lands in its bit
  task automatic rx_frame(input logic [7:0] val, input frame_form_t form, input bit noisy);
    int unsigned p, h, span, seg;
    logic lvl;
    p = cur_period;
    h = (p >> 1) == 0 ? 1 : p >> 1;
    span = (form == FR_GLITCH) ? h : h + 9 * p;
    repeat ($urandom_range(1, 3)) tick(1'b1);
    for (int unsigned i = 0; i <= span; i++) begin
      seg = (i <= h) ? 0 : (i - h + p - 1) / p;
      if (seg == 0)
        lvl = (form == FR_GLITCH && i > 0);
      else if (seg == 9)
        lvl = (form != FR_BAD_STOP);
      else
        lvl = val[seg - 1];
      if (noisy && $urandom_range(0, 11) == 0)
        host_noise();
      tick(lvl);
    end
  endtask

  task automatic tx_byte_out(input logic [7:0] val, input bit wild_rx);
    put_item(KIND_SEND, 1'($urandom), val);
    repeat (10 * int'(cur_period) + $urandom_range(0, 3))
      tick(wild_rx ? 1'($urandom) : 1'b1);
  endtask

  initial begin
    int unsigned act;
    bit fill;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle requests at reset period, then send/receive at the shortest period
    put_item(KIND_READ, 1'b0, 8'h00);
    put_item(KIND_CLEAR, 1'b1, 8'hFF);
    tick(1'b1);
    set_period(16'd1);
    put_item(KIND_SEND, 1'b1, 8'hFF);
    put_item(KIND_SEND, 1'b0, 8'h00);
    tick(1'b0);
    repeat (9) tick(1'b1);
    rx_frame(8'h00, FR_GOOD, 1'b0);
    put_item(KIND_READ, 1'b1, 8'hFF);
    put_item(KIND_READ, 1'b0, 8'h00);

    // random phases; the first one fills the receive buffer past full
    items_sent = 0;
    for (int ph = 0; items_sent < RAND_ITEMS; ph++) begin
      fill = (ph == 0) || ($urandom_range(0, 6) == 0);
      calm = ($urandom_range(0, 4) == 0);
      if (fill)
        set_period(16'($urandom_range(1, 2)));
      else if ($urandom_range(0, 5) == 0)
        set_period(16'($urandom_range(7, 12)));
      else
        set_period(16'($urandom_range(1, 6)));
      if (fill) begin
        repeat (DEPTH + 2) rx_frame(8'($urandom), FR_GOOD, 1'b0);
        repeat (DEPTH + 1) put_item(KIND_READ, 1'($urandom), 8'($urandom));
      end else begin
        for (int n = int'($urandom_range(6, 12)); n > 0 && items_sent < RAND_ITEMS; n--) begin
          act = $urandom_range(0, 9);
          case (act)
            0, 1, 2: rx_frame(8'($urandom), FR_GOOD, 1'b1);
            3:       rx_frame(8'($urandom), FR_BAD_STOP, 1'b1);
            4:       rx_frame(8'($urandom), FR_GLITCH, 1'b0);
            5:       tx_byte_out(8'($urandom), 1'($urandom_range(0, 1)));
            6:       repeat ($urandom_range(1, 4)) put_item(KIND_READ, 1'($urandom),
                                                            8'($urandom));
            7:       put_item(KIND_CLEAR, 1'($urandom), 8'($urandom));
            8:       repeat ($urandom_range(2, 8)) tick(1'($urandom));
            default: repeat ($urandom_range(1, 6))
                       put_item(kind_t'($urandom_range(0, 3)), 1'($urandom), 8'($urandom));
          endcase
        end
      end
    end

    // widest period: start check stays open, sends are turned away meanwhile
    calm = 1'b1;
    set_period(16'hFFFF);
    tick(1'b1);
    tick(1'b0);
    put_item(KIND_SEND, 1'b0, 8'hA5);
    repeat (40) tick(1'b1);
    put_item(KIND_SEND, 1'b1, 8'h5A);
    repeat (10) put_item(KIND_TICK, 1'b1, 8'h00);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Checked %0d replies over %0d random items plus directed and long-period runs;",
             replies_seen, RAND_ITEMS);
    $display("receiver stored %0d bytes, %0d overflows, %0d framing errors, %0d false starts.",
             bytes_stored, overflow_hits, framing_hits, false_starts);
    if (fail_count == 0 && replies_pending == 0) begin
      $display("** uart_8n1_transceiver_with_rx_fifo: PASSED **");
    end else begin
      $display("** uart_8n1_transceiver_with_rx_fifo: FAILED **");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #(8 * 600_000);
    $display("** uart_8n1_transceiver_with_rx_fifo: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
sv/uart8_pkg.sv
sv/uart8_rxq.sv
sv/uart_8n1_transceiver_with_rx_fifo.sv
sv/uart8_chk.sv
tb/uart_reply_checker.sv
tb/uart_8n1_transceiver_with_rx_fifo_tb.sv
